// ===== sv/rrla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring resource lock arbiter package
// Field widths, request and outcome codes, controller states and the
// command and status structures shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package rrla_pkg;

	localparam int unsigned FUNC_W    = 2;
	localparam int unsigned ID_W      = 5;
	localparam int unsigned OUTCOME_W = 3;
	localparam int unsigned RES_W     = 4;
	localparam int unsigned CFG_W     = 5;

	// Largest ring that the block supports; the field widths are sized for it.
	localparam int unsigned MAX_CLIENTS = 16;

	// Request codes carried by the func field.
	localparam logic [FUNC_W-1:0] FUNC_REQ_LEFT  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REQ_RIGHT = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED    = 2'd3;

	// Client count after reset.
	localparam logic [CFG_W-1:0] NUM_CLIENTS_RST = 5'd16;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_GRANTED      = 3'd0,
		OUT_QUEUED       = 3'd1,
		OUT_RELEASED     = 3'd2,
		OUT_BAD_ID       = 3'd3,
		OUT_WAIT_GRANT   = 3'd4
	} outcome_t;

	typedef struct packed {
		outcome_t          outcome;
		logic [ID_W-1:0]   grant_client;
		logic              grant_side;
		logic [RES_W-1:0]  resource_index;
		logic              last;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HEAD,
		ST_SCAN,
		ST_FLUSH
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;      // capture the incoming item
		logic head;       // answer the item itself
		logic scan_step;  // examine one client of the wait scan
		logic flush;      // hand over the held result as the final one
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_hit;   // the client under scan gets a waiting grant
		logic scan_last;  // the client under scan is the last in the ring
		logic out_free;   // the output register can take a result this cycle
	} dp_status_t;

endpackage

// ===== sv/rrla_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring resource lock arbiter channel interfaces
// Request, result and configuration channels, each a valid/ready transfer.
// ----------------------------------------------------------------------------
interface rrla_req_if;
	logic                        valid;
	logic                        ready;
	logic [rrla_pkg::FUNC_W-1:0] func;
	logic [rrla_pkg::ID_W-1:0]   client_id;

	modport source (output valid, func, client_id, input ready);
	modport sink   (input valid, func, client_id, output ready);
endinterface

interface rrla_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [rrla_pkg::OUTCOME_W-1:0] outcome;
	logic [rrla_pkg::ID_W-1:0]      grant_client;
	logic                           grant_side;
	logic [rrla_pkg::RES_W-1:0]     resource_index;
	logic                           last;

	modport source (output valid, outcome, grant_client, grant_side, resource_index, last,
		input ready);
	modport sink   (input valid, outcome, grant_client, grant_side, resource_index, last,
		output ready);
endinterface

interface rrla_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [rrla_pkg::CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== sv/rrla_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring resource lock arbiter controller
// Sequences one item: capture, answer, wait scan over the ring, final flush.
// ----------------------------------------------------------------------------
module rrla_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  rrla_pkg::dp_status_t status,
	output rrla_pkg::ctl_cmd_t   cmd
);

	rrla_pkg::ctl_state_t state_q;
	rrla_pkg::ctl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrla_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rrla_pkg::ST_IDLE: begin
				if (req_valid) state_nxt = rrla_pkg::ST_HEAD;
			end
			rrla_pkg::ST_HEAD: begin
				state_nxt = rrla_pkg::ST_SCAN;
			end
			rrla_pkg::ST_SCAN: begin
				if ((!status.scan_hit || status.out_free) && status.scan_last)
					state_nxt = rrla_pkg::ST_FLUSH;
			end
			rrla_pkg::ST_FLUSH: begin
				if (status.out_free) state_nxt = rrla_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = rrla_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready     = 1'b0;
		cmd           = '0;
		case (state_q)
			rrla_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.latch = req_valid;
			end
			rrla_pkg::ST_HEAD: begin
				cmd.head = 1'b1;
			end
			rrla_pkg::ST_SCAN: begin
				// A grant must wait until the held result can move on.
				cmd.scan_step = !status.scan_hit || status.out_free;
			end
			rrla_pkg::ST_FLUSH: begin
				cmd.flush = status.out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/rrla_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring resource lock arbiter datapath
// Resource and wait state, item answer, held result, output register and a
// wait scan of one client per cycle, paused at a grant while output is full.
// ----------------------------------------------------------------------------
module rrla_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rrla_pkg::ctl_cmd_t            cmd,
	output rrla_pkg::dp_status_t          status,
	input  logic [rrla_pkg::FUNC_W-1:0]   item_func,
	input  logic [rrla_pkg::ID_W-1:0]     item_client_id,
	input  logic                          cfg_valid,
	input  logic [rrla_pkg::CFG_W-1:0]    cfg_data,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output rrla_pkg::result_t             rsp_data
);

	localparam int unsigned NC = rrla_pkg::MAX_CLIENTS;
	localparam int unsigned IW = $clog2(NC);
	localparam int unsigned CW = $clog2(NC + 1);
	localparam int unsigned DW = rrla_pkg::ID_W;
	localparam int unsigned RW = rrla_pkg::RES_W;
	localparam logic [NC-1:0] BIT0 = NC'(1);

	logic [rrla_pkg::CFG_W-1:0]  num_clients_q;
	logic [rrla_pkg::FUNC_W-1:0] func_q;
	logic [rrla_pkg::ID_W-1:0]   id_q;
	logic [NC-1:0]               free_q;
	logic [NC-1:0]               wait_left_q;
	logic [NC-1:0]               wait_right_q;
	logic [IW-1:0]               idx_q;
	rrla_pkg::result_t           pend_q;
	rrla_pkg::result_t           out_q;
	logic                        out_valid_q;

	logic [CW-1:0] n_eff;
	logic [CW-1:0] p_id;
	logic [IW-1:0] id_left;
	logic [IW-1:0] id_right;
	logic [IW-1:0] id_slot;
	logic [IW-1:0] id_res;
	logic [NC-1:0] release_mask;
	logic          item_ok;
	logic          is_req;
	logic [CW-1:0] p_scan;
	logic [IW-1:0] scan_left;
	logic [IW-1:0] scan_right;
	logic          hit_right;
	logic          hit_left;
	logic          out_free;
	logic          push;
	rrla_pkg::result_t head_res;
	rrla_pkg::result_t scan_res;
	rrla_pkg::result_t push_res;

	// Effective ring size, the register clamped to the supported range.
	always_comb begin
		if (num_clients_q < 5'd2) begin
			n_eff = CW'(2);
		end else if (32'(num_clients_q) > NC) begin
			n_eff = CW'(NC);
		end else begin
			n_eff = CW'(num_clients_q);
		end
	end

	// Resources of the captured client.
	always_comb begin
		item_ok = (id_q != '0) && (32'(id_q) <= 32'(n_eff))
			&& (func_q != rrla_pkg::FUNC_UNUSED);
		p_id     = CW'(id_q);
		id_slot  = IW'(id_q - 5'd1);
		id_left  = (p_id < n_eff) ? IW'(p_id) : IW'(n_eff - CW'(1));
		id_right = (p_id < n_eff) ? IW'(p_id - CW'(1)) : '0;
		is_req   = (func_q == rrla_pkg::FUNC_REQ_LEFT)
			|| (func_q == rrla_pkg::FUNC_REQ_RIGHT);
		id_res   = (func_q == rrla_pkg::FUNC_REQ_RIGHT) ? id_right : id_left;
		release_mask = (BIT0 << id_left) | (BIT0 << id_right);
	end

	always_comb begin
		head_res                = '0;
		head_res.grant_client   = id_q;
		if (!item_ok) begin
			head_res.outcome = rrla_pkg::OUT_BAD_ID;
		end else if (is_req) begin
			head_res.outcome        = free_q[id_res] ? rrla_pkg::OUT_GRANTED
				: rrla_pkg::OUT_QUEUED;
			head_res.grant_side     = func_q[0];
			head_res.resource_index = RW'(id_res);
		end else begin
			head_res.outcome = rrla_pkg::OUT_RELEASED;
		end
	end

	// Client under scan: right side is tried before left.
	always_comb begin
		p_scan     = CW'(idx_q) + CW'(1);
		scan_right = (p_scan < n_eff) ? idx_q : '0;
		scan_left  = (p_scan < n_eff) ? IW'(p_scan) : IW'(n_eff - CW'(1));
		hit_right  = wait_right_q[idx_q] && free_q[scan_right];
		hit_left   = wait_left_q[idx_q] && free_q[scan_left];
		scan_res                = '0;
		scan_res.outcome        = rrla_pkg::OUT_WAIT_GRANT;
		scan_res.grant_client   = DW'(p_scan);
		scan_res.grant_side     = hit_right;
		scan_res.resource_index = RW'(hit_right ? scan_right : scan_left);
	end

	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		status.scan_hit  = hit_right || hit_left;
		status.scan_last = (idx_q == IW'(n_eff - CW'(1)));
		status.out_free  = out_free;
	end

	// The held result moves to the output register when a further result
	// follows it or when it is the final one.
	always_comb begin
		push          = (cmd.scan_step && status.scan_hit) || cmd.flush;
		push_res      = pend_q;
		push_res.last = cmd.flush;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clients_q <= rrla_pkg::NUM_CLIENTS_RST;
			free_q        <= '1;
			wait_left_q   <= '0;
			wait_right_q  <= '0;
			idx_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) num_clients_q <= cfg_data;
			if (cmd.head) begin
				idx_q <= '0;
				if (item_ok) begin
					if (is_req) begin
						if (free_q[id_res]) begin
							free_q[id_res] <= 1'b0;
						end else if (func_q == rrla_pkg::FUNC_REQ_RIGHT) begin
							wait_right_q[id_slot] <= 1'b1;
						end else begin
							wait_left_q[id_slot] <= 1'b1;
						end
					end else begin
						free_q <= free_q | release_mask;
					end
				end
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + IW'(1);
				if (hit_right) begin
					free_q[scan_right]  <= 1'b0;
					wait_right_q[idx_q] <= 1'b0;
				end else if (hit_left) begin
					free_q[scan_left]  <= 1'b0;
					wait_left_q[idx_q] <= 1'b0;
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= item_func;
			id_q   <= item_client_id;
		end
		if (cmd.head) pend_q <= head_res;
		if (cmd.scan_step && status.scan_hit) pend_q <= scan_res;
		if (push) out_q <= push_res;
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	a_push_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		((cmd.scan_step && status.scan_hit) || cmd.flush) |-> out_free)
		else $error("result pushed over one not yet taken");

	a_scan_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_step |-> (32'(idx_q) < 32'(n_eff)))
		else $error("wait scan beyond the ring");

	a_flush_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (out_valid_q && out_q.last))
		else $error("final result not presented with last set");

	a_bad_item_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.head && !item_ok) |=> ($stable(free_q) && $stable(wait_left_q)
			&& $stable(wait_right_q)))
		else $error("rejected item changed the lock state");

endmodule

// ===== sv/ring_resource_lock_arbiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring resource lock arbiter
// Grants the shared resources of a ring to clients that lock and release them.
// ----------------------------------------------------------------------------
// Usage. Clients 1..N share a ring of N resources; client p < N uses left
// resource p and right resource p-1, client N uses left N-1 and right 0.
// Each transfer on req carries a function code (request left, request right,
// release both) and the one-based client number. The block answers on rsp
// with one result for the item itself, then one result per waiting client
// that the following scan of the ring serves; last marks the final result of
// the item. The cfg channel writes the client count and is always ready; it
// is for the user to write only while the block is idle; nothing enforces it.
// Timing. An item is taken in the idle state and answered in the head state
// that follows; the wait scan then visits one client per cycle while the
// receiver does not stall, and this scan over the clients sets how long an
// item occupies the block. The answer to the item is held until the scan
// finds the next grant or ends, and only then moves to the output register.
// Reset leaves every resource free, no client waiting and the count at
// sixteen. When the receiver stalls, the result in the output register is
// held and the scan pauses at the next grant until that result is taken.
// ----------------------------------------------------------------------------
module ring_resource_lock_arbiter (
	input logic       clk,
	input logic       arst_n,
	rrla_req_if.sink  req,
	rrla_rsp_if.source rsp,
	rrla_cfg_if.sink  cfg
);

	// Command and status between the sequencer and the datapath.
	rrla_pkg::ctl_cmd_t   cmd;
	rrla_pkg::dp_status_t status;
	rrla_pkg::result_t    rsp_data;

	// The count register takes a write in every cycle it is offered.
	assign cfg.ready = 1'b1;

	rrla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	rrla_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.item_func      (req.func),
		.item_client_id (req.client_id),
		.cfg_valid      (cfg.valid),
		.cfg_data       (cfg.data),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_data       (rsp_data)
	);

	// Unpack the result register onto the result channel.
	assign rsp.outcome        = rsp_data.outcome;
	assign rsp.grant_client   = rsp_data.grant_client;
	assign rsp.grant_side     = rsp_data.grant_side;
	assign rsp.resource_index = rsp_data.resource_index;
	assign rsp.last           = rsp_data.last;

endmodule
